FILE: design/cbpp_pkg.sv
package cbpp_pkg;

	localparam logic [31:0] SYNC_WORD   = 32'hAA99_5566;
	localparam logic [31:0] DESYNC_CODE = 32'h0000_000D;
	localparam logic [13:0] CMD_REG     = 14'd4;

	localparam logic [2:0] HTYPE_ONE = 3'd1;
	localparam logic [2:0] HTYPE_TWO = 3'd2;

	localparam logic [1:0] OP_NOP   = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd2;

	localparam logic [1:0] LAST_BYTE = 2'd3;

	localparam logic KIND_PACKET = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NO_SYNC     = 3'd1,
		ST_TRUNCATED   = 3'd2,
		ST_ORPHAN_TWO  = 3'd3,
		ST_UNKNOWN     = 3'd4,
		ST_NO_DESYNC   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		PH_HUNT   = 4'b0001,
		PH_HEADER = 4'b0010,
		PH_DATA   = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       end_of_data;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic        record_kind;
		logic [2:0]  hdr_type;
		logic [1:0]  opcode;
		logic [13:0] reg_addr;
		logic [26:0] num_words;
		logic [31:0] data_offset;
		logic [2:0]  status;
		logic [31:0] sync_byte_index;
		logic [31:0] stream_length_bytes;
		logic [31:0] packet_count;
	} out_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] window;
		logic [1:0]  byte_in_word;
		logic [31:0] position;
		logic [31:0] sync_position;
		logic [26:0] words_remaining;
		logic        last_was_type_one;
		logic        desync_candidate;
		logic        config_ended;
		logic [2:0]  pend_type;
		logic [1:0]  pend_opcode;
		logic [13:0] pend_register;
		logic [26:0] pend_count;
		logic [31:0] pend_offset;
		logic [31:0] records;
		logic [31:0] stored_length;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase: PH_HUNT,
		default: '0
	};

endpackage

FILE: design/cbpp_step.sv
module cbpp_step (
	input  cbpp_pkg::parse_state_t cur,
	input  cbpp_pkg::in_item_t     item,
	output cbpp_pkg::parse_state_t nxt,
	output logic                   res_valid,
	output cbpp_pkg::out_item_t    res
);
	import cbpp_pkg::*;

	logic        do_emit;
	logic        do_finish;
	status_t     fin_status;
	logic [31:0] win_new;
	logic [1:0]  biw_inc;
	logic [26:0] rem_dec;
	logic [2:0]  htype;
	logic [1:0]  op;
	logic [13:0] reg_field;
	logic [26:0] cnt_one;
	logic [26:0] cnt_two;

	assign win_new   = {cur.window[23:0], item.data_byte};
	assign biw_inc   = cur.byte_in_word + 2'd1;
	assign rem_dec   = cur.words_remaining - 27'd1;
	assign htype     = win_new[31:29];
	assign op        = win_new[28:27];
	assign reg_field = win_new[26:13];
	assign cnt_one   = {16'd0, win_new[10:0]};
	assign cnt_two   = win_new[26:0];

	always_comb begin
		nxt        = cur;
		do_emit    = 1'b0;
		do_finish  = 1'b0;
		fin_status = ST_OK;
		if (cur.phase == PH_DONE) begin
			// parse over, beats are dropped
		end else if (item.end_of_data) begin
			do_finish = 1'b1;
			unique case (cur.phase)
				PH_HUNT: fin_status = ST_NO_SYNC;
				PH_DATA: fin_status = ST_TRUNCATED;
				default: fin_status = cur.config_ended ? ST_OK : ST_NO_DESYNC;
			endcase
		end else begin
			nxt.position = cur.position + 32'd1;
			nxt.window   = win_new;
			if (cur.phase == PH_HUNT) begin
				if (cur.byte_in_word == LAST_BYTE && win_new == SYNC_WORD) begin
					nxt.sync_position = cur.position - 32'd3;
					nxt.phase         = PH_HEADER;
					nxt.byte_in_word  = '0;
				end else if (cur.byte_in_word != LAST_BYTE) begin
					nxt.byte_in_word = biw_inc;
				end
			end else begin
				nxt.byte_in_word = biw_inc;
				if (biw_inc == 2'd0) begin
					if (cur.phase == PH_DATA) begin
						nxt.desync_candidate = cur.desync_candidate && win_new == DESYNC_CODE;
						nxt.words_remaining  = rem_dec;
						if (rem_dec == '0) begin
							if (nxt.desync_candidate)
								nxt.config_ended = 1'b1;
							nxt.desync_candidate = 1'b0;
							nxt.phase            = PH_HEADER;
							do_emit              = 1'b1;
						end
					end else if (cur.config_ended) begin
						// only padding NOPs are legal after desync
						if (htype == HTYPE_ONE && op == OP_NOP) begin
							nxt.last_was_type_one = 1'b1;
							nxt.pend_type         = HTYPE_ONE;
							nxt.pend_opcode       = OP_NOP;
							nxt.pend_register     = '0;
							nxt.pend_count        = '0;
							nxt.pend_offset       = nxt.position;
							do_emit               = 1'b1;
						end else begin
							do_finish = 1'b1;
						end
					end else if (htype == HTYPE_ONE) begin
						nxt.pend_type         = HTYPE_ONE;
						nxt.pend_opcode       = op;
						nxt.pend_register     = reg_field;
						nxt.pend_count        = cnt_one;
						nxt.pend_offset       = nxt.position;
						nxt.last_was_type_one = 1'b1;
						nxt.desync_candidate  = op == OP_WRITE && cnt_one == 27'd1
							&& reg_field == CMD_REG;
						if (cnt_one == '0) begin
							nxt.desync_candidate = 1'b0;
							do_emit              = 1'b1;
						end else begin
							nxt.words_remaining = cnt_one;
							nxt.phase           = PH_DATA;
						end
					end else if (htype == HTYPE_TWO) begin
						if (!cur.last_was_type_one) begin
							do_finish  = 1'b1;
							fin_status = ST_ORPHAN_TWO;
						end else begin
							nxt.pend_type         = HTYPE_TWO;
							nxt.pend_opcode       = op;
							nxt.pend_register     = '0;
							nxt.pend_count        = cnt_two;
							nxt.pend_offset       = nxt.position;
							nxt.last_was_type_one = 1'b0;
							nxt.desync_candidate  = 1'b0;
							if (cnt_two == '0) begin
								do_emit = 1'b1;
							end else begin
								nxt.words_remaining = cnt_two;
								nxt.phase           = PH_DATA;
							end
						end
					end else begin
						do_finish  = 1'b1;
						fin_status = ST_UNKNOWN;
					end
				end
			end
		end

		if (do_emit) begin
			nxt.records       = cur.records + 32'd1;
			nxt.stored_length = nxt.position;
		end
		if (do_finish)
			nxt.phase = PH_DONE;
	end

	always_comb begin
		res_valid = do_emit || do_finish;
		res       = '0;
		res.sync_byte_index     = nxt.sync_position;
		res.stream_length_bytes = nxt.stored_length;
		res.packet_count        = nxt.records;
		if (do_finish) begin
			res.record_kind = KIND_STATUS;
			res.status      = fin_status;
		end else begin
			res.record_kind = KIND_PACKET;
			res.hdr_type    = nxt.pend_type;
			res.opcode      = nxt.pend_opcode;
			res.reg_addr    = nxt.pend_register;
			res.num_words   = nxt.pend_count;
			res.data_offset = nxt.pend_offset;
		end
	end

endmodule

FILE: design/config_bitstream_packet_parser_unit.sv
// Configuration bitstream packet parser. Bytes enter one per beat on the
// input channel; the block hunts the sync word at any byte alignment, then
// assembles big-endian words, decodes type-1 and type-2 headers and counts
// data words. Each completed packet gives one record beat; the end marker
// (end_of_data) or the first error gives one final status beat, after which
// input beats are still taken but dropped until reset. Throughput is one byte
// per clock while the output is not stalled: a beat is registered in the
// input register, one pass of the parse logic runs on it against the state
// registers and the outcome lands in the output register. A stall on the
// output holds the input register, which then backs up the input.
module config_bitstream_packet_parser_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cbpp_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cbpp_pkg::out_item_t out_data
);
	import cbpp_pkg::*;

	// input register
	logic     item_valid_s1;
	in_item_t item_s1;

	// parse state and step outcome
	parse_state_t state_q;
	parse_state_t state_next;
	logic         step_res_valid;
	out_item_t    step_res;

	logic advance;

	// the byte in the input register is parsed once the output register has room
	assign advance  = item_valid_s1 && (!out_valid || out_ready);
	assign in_ready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			item_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_data;
	end

	cbpp_step u_step (
		.cur       (state_q),
		.item      (item_s1),
		.nxt       (state_next),
		.res_valid (step_res_valid),
		.res       (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// output register: cleared when taken, loaded when a step yields a beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= step_res_valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_res_valid)
			out_data <= step_res;
	end

	// once done, the parse never restarts without reset
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_DONE |=> state_q.phase == PH_DONE)
		else $error("parser left done phase");

	// every packet record bumps the record counter by one
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && step_res_valid && step_res.record_kind == KIND_PACKET
		|=> state_q.records == $past(state_q.records) + 32'd1)
		else $error("packet record without counter step");

	// packet records always carry an ok status
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.record_kind == KIND_PACKET |-> out_data.status == ST_OK)
		else $error("packet record with error status");

	// input stalls only when the input register holds a byte that cannot advance
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> item_valid_s1 && out_valid && !out_ready)
		else $error("input stalled without cause");

endmodule
